>>> rtl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Beat types, operation codes and sequencer states of the running statistics
// accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam int SUM_BITS = 64;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] sample;
	} req_t;

	typedef struct packed {
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
		logic signed [31:0] average;
		logic        [31:0] positives;
		logic        [31:0] negatives;
		logic signed [63:0] odd_total;
		logic signed [63:0] even_total;
		logic               ends_match;
		logic        [31:0] total_seen;
		logic               is_empty;
		logic               saturated;
	} rpt_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIVIDE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_LOAD,
		DV_STEP,
		DV_SIGN,
		DV_DONE
	} div_state_t;

endpackage

>>> rtl/rsa_stats.sv
// ----------------------------------------------------------------------------
// rsa_stats
// Statistic registers: min, max, first sample, sign counts, odd and even sums,
// sample count, match and drop flags.
// ----------------------------------------------------------------------------
module rsa_stats import rsa_pkg::*; #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output rpt_t                          summary,
	output logic signed [SUM_BITS-1:0]    total,
	output logic        [COUNT_BITS-1:0]  count
);

	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] first_q;
	logic signed [SUM_BITS-1:0]    odd_q;
	logic signed [SUM_BITS-1:0]    even_q;
	logic        [COUNT_BITS-1:0]  cnt_q;
	logic        [COUNT_BITS-1:0]  pos_q;
	logic        [COUNT_BITS-1:0]  neg_q;
	logic                          match_q;
	logic                          drop_q;
	logic                          full;
	logic                          empty;

	assign full  = &cnt_q;
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= '0;
			first_q <= '0;
			odd_q   <= '0;
			even_q  <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			neg_q   <= '0;
			match_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (upd) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				if (empty) begin
					min_q   <= sample;
					max_q   <= sample;
					first_q <= sample;
					match_q <= 1'b1;
				end else begin
					if (sample > max_q) begin
						max_q <= sample;
					end
					if (sample < min_q) begin
						min_q <= sample;
					end
					match_q <= (sample == first_q);
				end
				if (sample[SAMPLE_BITS-1]) begin
					neg_q <= neg_q + COUNT_BITS'(1);
				end else if (sample != '0) begin
					pos_q <= pos_q + COUNT_BITS'(1);
				end
				if (sample[0]) begin
					odd_q <= odd_q + SUM_BITS'(sample);
				end else begin
					even_q <= even_q + SUM_BITS'(sample);
				end
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end
		end
	end

	always_comb begin
		summary.smallest   = empty ? '0 : 32'(min_q);
		summary.largest    = empty ? '0 : 32'(max_q);
		summary.average    = '0;
		summary.positives  = 32'(pos_q);
		summary.negatives  = 32'(neg_q);
		summary.odd_total  = odd_q;
		summary.even_total = even_q;
		summary.ends_match = !empty && match_q;
		summary.total_seen = 32'(cnt_q);
		summary.is_empty   = empty;
		summary.saturated  = drop_q;
	end

	assign total = odd_q + even_q;
	assign count = cnt_q;

endmodule

>>> rtl/rsa_div.sv
// ----------------------------------------------------------------------------
// rsa_div
// Restoring divider, one quotient bit per cycle, signed dividend over an
// unsigned count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rsa_div import rsa_pkg::*; #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0]      divisor,
	output logic                       done,
	output logic signed [SUM_BITS-1:0] quotient
);

	localparam int DW = SAMPLE_BITS + COUNT_BITS;
	localparam int SW = $clog2(DW);
	localparam logic [SW-1:0] STEP_TOP = SW'(DW - 1);

	div_state_t                 state_q;
	div_state_t                 state_d;
	logic                       neg_q;
	logic signed [SUM_BITS-1:0] tot_q;
	logic [COUNT_BITS-1:0]      dvs_q;
	logic [DW-1:0]              num_q;
	logic [COUNT_BITS-1:0]      rem_q;
	logic [SW-1:0]              step_q;
	logic signed [SUM_BITS-1:0] quot_q;
	logic [COUNT_BITS:0]        trial;
	logic [COUNT_BITS:0]        diff;
	logic                       ge;

	assign trial = {rem_q, num_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE, DV_DONE: begin
				if (start) begin
					state_d = DV_LOAD;
				end
			end
			DV_LOAD: begin
				state_d = DV_STEP;
			end
			DV_STEP: begin
				if (step_q == '0) begin
					state_d = DV_SIGN;
				end
			end
			DV_SIGN: begin
				state_d = DV_DONE;
			end
			default: begin
				state_d = DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE, DV_DONE: begin
				if (start) begin
					neg_q <= dividend[SUM_BITS-1];
					tot_q <= dividend;
					dvs_q <= divisor;
				end
			end
			DV_LOAD: begin
				num_q  <= DW'(neg_q ? -tot_q : tot_q);
				rem_q  <= '0;
				step_q <= STEP_TOP;
			end
			DV_STEP: begin
				rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
				num_q  <= {num_q[DW-2:0], ge};
				step_q <= step_q - SW'(1);
			end
			DV_SIGN: begin
				quot_q <= neg_q ? -SUM_BITS'(num_q) : SUM_BITS'(num_q);
			end
			default: begin
			end
		endcase
	end

	assign done     = (state_q == DV_DONE);
	assign quotient = quot_q;

endmodule

>>> rtl/running_statistics_accumulator.sv
// ----------------------------------------------------------------------------
// running_statistics_accumulator
// Running min, max, sign counts, odd/even sums and mean of signed samples,
// reported on request.
// ----------------------------------------------------------------------------
//   channel  dir  payload  beat
//   req      in   req_t    add a sample or request a report
//   rpt      out  rpt_t    one statistics report per request
//
// A sample beat does not stall the request channel; a new beat is taken in the next cycle.
// A report beat is formed by the restoring divider, which loads, forms one quotient
// bit per cycle, applies the sign and signals done; req_ready stays low until
// the report is in the output register.
// Reset clears every statistic; the first sample seeds min, max and first.
// A report held by rpt_ready does not block sample beats; a following report
// waits for the output register before it is loaded.
// ----------------------------------------------------------------------------
module running_statistics_accumulator import rsa_pkg::*; #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rpt_valid,
	input  logic rpt_ready,
	output rpt_t rpt
);

	ctrl_state_t                state_q;
	ctrl_state_t                state_d;
	logic                       upd;
	logic                       div_start;
	logic                       div_done;
	logic                       load_out;
	rpt_t                       summary;
	logic signed [SUM_BITS-1:0] total;
	logic [COUNT_BITS-1:0]      count;
	logic signed [SUM_BITS-1:0] quot;
	rpt_t                       rpt_d;
	rpt_t                       rpt_q;
	logic                       rpt_valid_q;

	assign upd = req_valid && req_ready && (req.operation == OP_ADD);

	rsa_stats #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sample (req.sample[SAMPLE_BITS-1:0]),
		.summary(summary),
		.total  (total),
		.count  (count)
	);

	rsa_div #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(total),
		.divisor (count),
		.done    (div_done),
		.quotient(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && (req.operation == OP_REPORT)) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done && (!rpt_valid_q || rpt_ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rpt_d         = summary;
		rpt_d.average = summary.is_empty ? '0 : quot[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (load_out) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rpt_q <= rpt_d;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

>>> rtl/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the running statistics accumulator, bound to the top.
// ----------------------------------------------------------------------------
module rsa_checker import rsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rpt_valid,
	input logic rpt_ready,
	input rpt_t rpt
);

	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
		else $error("report beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.operation == OP_REPORT) |=> !req_ready)
		else $error("request taken during report");

	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.is_empty |->
			(rpt.smallest == 0) && (rpt.largest == 0) && (rpt.average == 0) &&
			(rpt.total_seen == 0) && !rpt.ends_match)
		else $error("empty report carries statistics");

	assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt.is_empty |->
			(rpt.smallest <= rpt.average) && (rpt.average <= rpt.largest))
		else $error("mean outside min and max");

endmodule

bind running_statistics_accumulator rsa_checker u_rsa_checker (.*);

>>> verif/rsa_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_stats_checker
// Watches the request and report channels of the running statistics
// accumulator, keeps its own running statistics from every accepted request
// beat and compares each accepted report, field by field, with the oldest
// expected one.
// ----------------------------------------------------------------------------
module rsa_stats_checker import rsa_pkg::*; #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rpt_valid,
	input  logic rpt_ready,
	input  rpt_t rpt,
	output int   mismatches,
	output int   pending
);

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	longint          low_mark;
	longint          high_mark;
	longint          first_sample;
	longint          odd_sum;
	longint          even_sum;
	longint unsigned samples_taken;
	logic   [31:0]   above_zero;
	logic   [31:0]   below_zero;
	logic            matches_first;
	logic            overflowed;
	rpt_t            expected_reports[$];

	task automatic fold_in_beat(input req_t beat);
		longint value;
		longint mean;
		rpt_t   want;
		value = $signed(beat.sample[SAMPLE_BITS-1:0]);
		if (beat.operation == OP_ADD) begin
			if (samples_taken >= COUNT_MAX) begin
				overflowed = 1'b1;
			end else begin
				if (samples_taken == 0) begin
					low_mark     = value;
					high_mark    = value;
					first_sample = value;
				end else begin
					if (value > high_mark) high_mark = value;
					if (value < low_mark) low_mark = value;
				end
				if (value > 0) above_zero = above_zero + 32'd1;
				else if (value < 0) below_zero = below_zero + 32'd1;
				if (value[0]) odd_sum = odd_sum + value;
				else even_sum = even_sum + value;
				matches_first = (value == first_sample);
				samples_taken = samples_taken + 1;
			end
		end else begin
			mean = 0;
			if (samples_taken != 0)
				mean = (odd_sum + even_sum) / longint'(samples_taken);
			want.smallest   = (samples_taken == 0) ? 32'd0 : low_mark[31:0];
			want.largest    = (samples_taken == 0) ? 32'd0 : high_mark[31:0];
			want.average    = mean[31:0];
			want.positives  = above_zero;
			want.negatives  = below_zero;
			want.odd_total  = odd_sum;
			want.even_total = even_sum;
			want.ends_match = (samples_taken != 0) && matches_first;
			want.total_seen = samples_taken[31:0];
			want.is_empty   = (samples_taken == 0);
			want.saturated  = overflowed;
			expected_reports.push_back(want);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: report field %s mismatch, expected %h, actual %h",
				$time, name, want, got);
			mismatches = mismatches + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mark      = 0;
			high_mark     = 0;
			first_sample  = 0;
			odd_sum       = 0;
			even_sum      = 0;
			samples_taken = 0;
			above_zero    = '0;
			below_zero    = '0;
			matches_first = 1'b0;
			overflowed    = 1'b0;
			mismatches    = 0;
			expected_reports.delete();
		end else begin
			if (req_valid && req_ready)
				fold_in_beat(req);
			if (rpt_valid && rpt_ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report beat with none expected, expected none, actual %h",
						$time, rpt);
					mismatches = mismatches + 1;
				end else begin
					check_field("smallest", 64'(expected_reports[0].smallest),
						64'(rpt.smallest));
					check_field("largest", 64'(expected_reports[0].largest),
						64'(rpt.largest));
					check_field("average", 64'(expected_reports[0].average),
						64'(rpt.average));
					check_field("positives", 64'(expected_reports[0].positives),
						64'(rpt.positives));
					check_field("negatives", 64'(expected_reports[0].negatives),
						64'(rpt.negatives));
					check_field("odd_total", expected_reports[0].odd_total,
						rpt.odd_total);
					check_field("even_total", expected_reports[0].even_total,
						rpt.even_total);
					check_field("ends_match", 64'(expected_reports[0].ends_match),
						64'(rpt.ends_match));
					check_field("total_seen", 64'(expected_reports[0].total_seen),
						64'(rpt.total_seen));
					check_field("is_empty", 64'(expected_reports[0].is_empty),
						64'(rpt.is_empty));
					check_field("saturated", 64'(expected_reports[0].saturated),
						64'(rpt.saturated));
					void'(expected_reports.pop_front());
				end
			end
		end
		pending = expected_reports.size();
	end

endmodule

>>> verif/tb_running_statistics_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_statistics_accumulator
// Drives sample and report beats into the running statistics accumulator under
// random idling on both channels and leaves the checking to a side checker.
// ----------------------------------------------------------------------------
module tb_running_statistics_accumulator;
	import rsa_pkg::*;

	localparam int SMP_BITS    = 32;
	localparam int CNT_BITS    = 32;
	localparam int DRAIN       = SMP_BITS + CNT_BITS + 20;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rpt_valid;
	logic rpt_ready;
	rpt_t rpt;
	int   mismatches;
	int   pending;
	int   send_idle;
	int   recv_idle;
	int   quiet_cycles;
	logic signed [31:0] first_value;

	running_statistics_accumulator #(
		.SAMPLE_BITS(SMP_BITS),
		.COUNT_BITS (CNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rpt_valid(rpt_valid),
		.rpt_ready(rpt_ready),
		.rpt      (rpt)
	);

	rsa_stats_checker #(
		.SAMPLE_BITS(SMP_BITS),
		.COUNT_BITS (CNT_BITS)
	) stats_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rpt_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rpt_valid && rpt_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_beat(input logic op, input logic signed [31:0] value);
		req_t beat;
		beat.operation = op;
		beat.sample    = value;
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_random(input int beats);
		logic               op;
		logic signed [31:0] value;
		repeat (beats) begin
			op = ($urandom_range(0, 7) == 0) ? OP_REPORT : OP_ADD;
			case ($urandom_range(0, 5))
				0: begin
					case ($urandom_range(0, 6))
						0: value = 32'h8000_0000;
						1: value = 32'h7fff_ffff;
						2: value = 32'h0000_0000;
						3: value = 32'h0000_0001;
						4: value = 32'hffff_ffff;
						5: value = 32'h8000_0001;
						default: value = 32'h7fff_fffe;
					endcase
				end
				1: value = first_value;
				2: value = $urandom_range(0, 32) - 16;
				default: value = $urandom;
			endcase
			send_beat(op, value);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rpt_ready    = 1'b0;
		quiet_cycles = 0;
		send_idle    = 14;
		recv_idle    = 58;
		first_value  = 32'sd1000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(OP_REPORT, $urandom);
		send_beat(OP_ADD, first_value);
		send_beat(OP_REPORT, $urandom);
		send_beat(OP_ADD, first_value);
		send_beat(OP_REPORT, $urandom);
		send_beat(OP_ADD, 32'h7fff_ffff);
		send_beat(OP_ADD, 32'h8000_0000);
		send_beat(OP_ADD, 32'h0000_0000);
		send_beat(OP_ADD, 32'h0000_0001);
		send_beat(OP_ADD, 32'hffff_ffff);
		send_beat(OP_REPORT, $urandom);
		send_beat(OP_ADD, first_value);
		send_beat(OP_REPORT, $urandom);
		send_beat(OP_REPORT, $urandom);
		send_beat(OP_ADD, 32'h8000_0001);
		send_beat(OP_ADD, 32'hffff_fffe);
		send_beat(OP_ADD, 32'h0000_0003);
		send_beat(OP_REPORT, $urandom);

		send_random(530);
		send_idle = 58;
		recv_idle = 14;
		send_random(530);
		send_idle = 0;
		recv_idle = 0;
		send_random(540);
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
